/* sv/mgpid_pkg.sv */
package mgpid_pkg;

  // field widths
  localparam int ERR_W    = 12;
  localparam int ES_W     = 10;
  localparam int GAIN_W   = 16;
  localparam int BASE_W   = 8;
  localparam int DRIVE_W  = 9;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W = 3;

  // integral clamp, fixed point, adjustment and speed limits
  localparam int SUM_LIMIT = 500;
  localparam int Q_SHIFT   = 12;
  localparam int ADJ_LIMIT = 80;
  localparam int SPEED_MIN = 50;
  localparam int SPEED_MAX = 255;

  // derived widths
  localparam int SUM_W = ((ERR_W > ES_W) ? ERR_W : ES_W) + 1;
  localparam int DER_W = ERR_W + 1;
  localparam int PKP_W = GAIN_W + 1 + ERR_W;
  localparam int PKI_W = GAIN_W + 1 + ES_W;
  localparam int PKD_W = GAIN_W + 1 + DER_W;
  localparam int ACC_W = ((PKP_W > PKD_W) ? PKP_W : PKD_W) + 2;
  localparam int ADJ_W = 8;
  localparam int SPD_W = BASE_W + 2;

  typedef enum logic [KIND_W-1:0] {
    MODE_WAIT   = 3'd0,
    MODE_FWD    = 3'd1,
    MODE_REV_L  = 3'd2,
    MODE_REV_R  = 3'd3,
    MODE_SRCH_L = 3'd4,
    MODE_SRCH_R = 3'd5
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FWD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_REV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SRCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FWD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_REV  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SRCH = 3'd7;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [BASE_W-1:0] base_fwd;
    logic [BASE_W-1:0] base_rev;
    logic [BASE_W-1:0] base_srch;
    logic [GAIN_W-1:0] kp_rev;
    logic [GAIN_W-1:0] kp_srch;
  } cfg_t;

  // operands after the integral and derivative update
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [ES_W-1:0]  sum;
    logic signed [DER_W-1:0] deriv;
    logic [GAIN_W-1:0]       kp;
    logic [GAIN_W-1:0]       ki;
    logic [GAIN_W-1:0]       kd;
    logic [BASE_W-1:0]       base;
    logic                    fwd_route;
    logic                    stop;
  } opnd_t;

  // the three weighted terms
  typedef struct packed {
    logic signed [PKP_W-1:0] p_kp;
    logic signed [PKI_W-1:0] p_ki;
    logic signed [PKD_W-1:0] p_kd;
    logic [BASE_W-1:0]       base;
    logic                    fwd_route;
    logic                    stop;
  } prod_t;

endpackage

/* sv/mode_gain_pid_differential_drive_unit.sv */
// an accepted word passes the operand, product and output registers in order
// throughput: one word per cycle while the output is free or taken; the error
//   sum and last error update on accept, so the next word sees them at once
// the three pipeline stages advance together while the output is free or taken
// reset (async, active low) clears the valid bits, error sum and last error,
//   and loads the gain and base speed registers with their default values
module mode_gain_pid_differential_drive_unit
  import mgpid_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [GAIN_W-1:0]         cfg_data_i,
  // input word
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ERR_W-1:0]   position_error_i,
  input  logic [KIND_W-1:0]         kind_i,
  // result word
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [DRIVE_W-1:0] motor_a_drive_o,
  output logic signed [DRIVE_W-1:0] motor_b_drive_o,
  output logic                      stopped_o
);

  cfg_t  cfg_q;
  opnd_t opnd;
  prod_t prod;
  logic  v1_q, v2_q, v3_q;
  logic  en;
  logic  accept;

  // whole pipe moves when the output register is empty or being drained
  assign en         = !v3_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp        <= GAIN_W'(410);
      cfg_q.kp_rev    <= GAIN_W'(614);
      cfg_q.kp_srch   <= GAIN_W'(205);
      cfg_q.ki        <= '0;
      cfg_q.kd        <= '0;
      cfg_q.base_fwd  <= BASE_W'(70);
      cfg_q.base_rev  <= BASE_W'(49);
      cfg_q.base_srch <= BASE_W'(50);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GAIN_FWD:  cfg_q.kp        <= cfg_data_i;
        REG_GAIN_REV:  cfg_q.kp_rev    <= cfg_data_i;
        REG_GAIN_SRCH: cfg_q.kp_srch   <= cfg_data_i;
        REG_GAIN_INT:  cfg_q.ki        <= cfg_data_i;
        REG_GAIN_DER:  cfg_q.kd        <= cfg_data_i;
        REG_BASE_FWD:  cfg_q.base_fwd  <= cfg_data_i[BASE_W-1:0];
        REG_BASE_REV:  cfg_q.base_rev  <= cfg_data_i[BASE_W-1:0];
        REG_BASE_SRCH: cfg_q.base_srch <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign out_valid_o = v3_q;

  // stage 1: mode decode, integral and derivative, state update
  mgpid_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .en_i     (en),
    .err_i    (position_error_i),
    .kind_i   (kind_i),
    .cfg_i    (cfg_q),
    .opnd_o   (opnd)
  );

  // stage 2: the three gain products
  mgpid_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (en),
    .opnd_i (opnd),
    .prod_o (prod)
  );

  // stage 3: sum, clamp, wheel speeds, motor routing
  mgpid_mix u_mix (
    .clk_i           (clk_i),
    .en_i            (en),
    .prod_i          (prod),
    .motor_a_drive_o (motor_a_drive_o),
    .motor_b_drive_o (motor_b_drive_o),
    .stopped_o       (stopped_o)
  );

endmodule

/* sv/mgpid_front.sv */
module mgpid_front
  import mgpid_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     en_i,
  input  logic signed [ERR_W-1:0]  err_i,
  input  logic [KIND_W-1:0]        kind_i,
  input  cfg_t                     cfg_i,
  output opnd_t                    opnd_o
);

  localparam logic signed [SUM_W-1:0] LIM_P = SUM_W'(SUM_LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_N = -SUM_W'(SUM_LIMIT);

  logic signed [ES_W-1:0]  sum_q;
  logic signed [ERR_W-1:0] last_q;
  logic signed [SUM_W-1:0] sum_w;
  logic signed [ES_W-1:0]  sum_c;
  opnd_t                   opnd_d, opnd_q;

  always_comb begin
    sum_w = SUM_W'(sum_q) + SUM_W'(err_i);
    if (sum_w > LIM_P) begin
      sum_c = ES_W'(LIM_P);
    end else if (sum_w < LIM_N) begin
      sum_c = ES_W'(LIM_N);
    end else begin
      sum_c = ES_W'(sum_w);
    end

    opnd_d.err   = err_i;
    opnd_d.sum   = sum_c;
    opnd_d.deriv = DER_W'(err_i) - DER_W'(last_q);
    opnd_d.ki    = cfg_i.ki;
    opnd_d.kd    = cfg_i.kd;
    opnd_d.stop  = 1'b0;
    case (mode_e'(kind_i))
      MODE_WAIT: begin
        opnd_d.kp        = cfg_i.kp;
        opnd_d.base      = cfg_i.base_fwd;
        opnd_d.fwd_route = 1'b1;
        opnd_d.stop      = 1'b1;
      end
      MODE_FWD: begin
        opnd_d.kp        = cfg_i.kp;
        opnd_d.base      = cfg_i.base_fwd;
        opnd_d.fwd_route = 1'b1;
      end
      MODE_REV_L, MODE_REV_R: begin
        opnd_d.kp        = cfg_i.kp_rev;
        opnd_d.base      = cfg_i.base_rev;
        opnd_d.fwd_route = 1'b0;
      end
      MODE_SRCH_L, MODE_SRCH_R: begin
        opnd_d.kp        = cfg_i.kp_srch;
        opnd_d.base      = cfg_i.base_srch;
        opnd_d.fwd_route = 1'b1;
      end
      default: begin
        // unknown codes: forward gains, reverse wiring
        opnd_d.kp        = cfg_i.kp;
        opnd_d.base      = cfg_i.base_fwd;
        opnd_d.fwd_route = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      last_q <= '0;
    end else if (accept_i) begin
      if (mode_e'(kind_i) == MODE_WAIT) begin
        sum_q  <= '0;
        last_q <= '0;
      end else begin
        sum_q  <= sum_c;
        last_q <= err_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opnd_q <= opnd_d;
    end
  end

  assign opnd_o = opnd_q;

endmodule

/* sv/mgpid_mult.sv */
module mgpid_mult
  import mgpid_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  opnd_t opnd_i,
  output prod_t prod_o
);

  prod_t prod_d, prod_q;

  always_comb begin
    prod_d.p_kp      = PKP_W'($signed({1'b0, opnd_i.kp}) * opnd_i.err);
    prod_d.p_ki      = PKI_W'($signed({1'b0, opnd_i.ki}) * opnd_i.sum);
    prod_d.p_kd      = PKD_W'($signed({1'b0, opnd_i.kd}) * opnd_i.deriv);
    prod_d.base      = opnd_i.base;
    prod_d.fwd_route = opnd_i.fwd_route;
    prod_d.stop      = opnd_i.stop;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* sv/mgpid_mix.sv */
module mgpid_mix
  import mgpid_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  prod_t                     prod_i,
  output logic signed [DRIVE_W-1:0] motor_a_drive_o,
  output logic signed [DRIVE_W-1:0] motor_b_drive_o,
  output logic                      stopped_o
);

  localparam logic signed [ACC_W-1:0] LIM_P = ACC_W'(ADJ_LIMIT * (2 ** Q_SHIFT));
  localparam logic signed [ACC_W-1:0] LIM_N = -ACC_W'(ADJ_LIMIT * (2 ** Q_SHIFT));
  localparam logic signed [ACC_W-1:0] RND   = ACC_W'((2 ** Q_SHIFT) - 1);
  localparam logic signed [SPD_W-1:0] SP_MIN = SPD_W'(SPEED_MIN);
  localparam logic signed [SPD_W-1:0] SP_MAX = SPD_W'(SPEED_MAX);

  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_b;
  logic signed [ADJ_W-1:0]   adj;
  logic signed [SPD_W-1:0]   base_s, left_w, right_w, left_c, right_c;
  logic signed [DRIVE_W-1:0] drv_a_d, drv_b_d, drv_a_q, drv_b_q;
  logic                      stop_q;

  always_comb begin
    acc = ACC_W'(prod_i.p_kp) + ACC_W'(prod_i.p_ki) + ACC_W'(prod_i.p_kd);
    // bias negatives so the shift truncates toward zero
    acc_b = acc[ACC_W-1] ? acc + RND : acc;
    if (acc > LIM_P) begin
      adj = ADJ_W'(ADJ_LIMIT);
    end else if (acc < LIM_N) begin
      adj = -ADJ_W'(ADJ_LIMIT);
    end else begin
      adj = ADJ_W'(acc_b >>> Q_SHIFT);
    end

    base_s  = $signed({2'b00, prod_i.base});
    left_w  = base_s - SPD_W'(adj);
    right_w = base_s + SPD_W'(adj);
    if (left_w > SP_MAX) begin
      left_c = SP_MAX;
    end else if (left_w < SP_MIN) begin
      left_c = SP_MIN;
    end else begin
      left_c = left_w;
    end
    if (right_w > SP_MAX) begin
      right_c = SP_MAX;
    end else if (right_w < SP_MIN) begin
      right_c = SP_MIN;
    end else begin
      right_c = right_w;
    end

    if (prod_i.stop) begin
      drv_a_d = '0;
      drv_b_d = '0;
    end else if (prod_i.fwd_route) begin
      drv_a_d = DRIVE_W'(left_c);
      drv_b_d = DRIVE_W'(right_c);
    end else begin
      drv_a_d = -DRIVE_W'(right_c);
      drv_b_d = -DRIVE_W'(left_c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drv_a_q <= drv_a_d;
      drv_b_q <= drv_b_d;
      stop_q  <= prod_i.stop;
    end
  end

  assign motor_a_drive_o = drv_a_q;
  assign motor_b_drive_o = drv_b_q;
  assign stopped_o       = stop_q;

endmodule
